>>> design/sdspi_pkg.sv
// Shared types, codes and command frame tables of the SD SPI-mode host sequencer.
`default_nettype none
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned CntW = 10;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_CARD  = 2'd1,
    KIND_WDATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_CARD_TYPE  = 3'd0,
    CFG_RESP_POLL  = 3'd1,
    CFG_TOKEN_WAIT = 3'd2,
    CFG_IDLE_RETRY = 3'd3,
    CFG_INIT_RETRY = 3'd4,
    CFG_BUSY_WAIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOKEN_TO = 3'd1,
    ST_WREJECT  = 3'd2,
    ST_BUSY_TO  = 3'd3,
    ST_INIT_ERR = 3'd4,
    ST_CMD_ERR  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    T_CMD0   = 3'd0,
    T_CMD8   = 3'd1,
    T_CMD55I = 3'd2,
    T_ACMD41 = 3'd3,
    T_CMD17  = 3'd4,
    T_CMD55W = 3'd5,
    T_CMD23  = 3'd6,
    T_CMD24  = 3'd7
  } tag_e;

  localparam logic [1:0] CardBlock = 2'd1;
  localparam logic [1:0] CardMmc   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [31:0] sector;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_low;
    logic       slow_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       data_request;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic [1:0]  card_type;
    logic [7:0]  resp_poll;
    logic [15:0] token_wait;
    logic [7:0]  idle_retry;
    logic [15:0] init_retry;
    logic [15:0] busy_wait;
  } cfg_t;

  function automatic logic [7:0] frame_byte(tag_e t, logic [2:0] i, logic [31:0] addr);
    logic [31:0] arg;
    logic [7:0]  idx;
    logic [7:0]  crc;
    arg = 32'd0;
    idx = 8'h40;
    crc = 8'h01;
    case (t)
      T_CMD0:   begin idx = 8'h40; crc = 8'h95; end
      T_CMD8:   begin idx = 8'h48; crc = 8'h87; arg = 32'h0000_01AA; end
      T_CMD55I: idx = 8'h77;
      T_ACMD41: begin idx = 8'h69; arg = 32'h4000_0000; end
      T_CMD17:  begin idx = 8'h51; arg = addr; end
      T_CMD55W: idx = 8'h77;
      T_CMD23:  begin idx = 8'h57; arg = 32'd1; end
      T_CMD24:  begin idx = 8'h58; arg = addr; end
      default:  idx = 8'h40;
    endcase
    case (i)
      3'd0:    frame_byte = idx;
      3'd1:    frame_byte = arg[31:24];
      3'd2:    frame_byte = arg[23:16];
      3'd3:    frame_byte = arg[15:8];
      3'd4:    frame_byte = arg[7:0];
      default: frame_byte = crc;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> design/sdspi_if.sv
// Valid/ready channel interfaces for item, result and configuration beats.
`default_nettype none
interface sdspi_in_if;
  logic            valid;
  logic            ready;
  sdspi_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_out_if;
  logic            valid;
  logic            ready;
  sdspi_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> design/sdspi_cfg_regs.sv
// Configuration register bank.
`default_nettype none
module sdspi_cfg_regs (
  input  wire             clk_i,
  input  wire             rst_ni,
  sdspi_cfg_if.sink       cfg,
  output sdspi_pkg::cfg_t cfg_o
);
  sdspi_pkg::cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_type  <= 2'd0;
      cfg_q.resp_poll  <= 8'd31;
      cfg_q.token_wait <= 16'hFFFF;
      cfg_q.idle_retry <= 8'd20;
      cfg_q.init_retry <= 16'hFFFE;
      cfg_q.busy_wait  <= 16'hFFFE;
    end else if (cfg.valid) begin
      case (cfg.index)
        sdspi_pkg::CFG_CARD_TYPE:  cfg_q.card_type  <= cfg.wdata[1:0];
        sdspi_pkg::CFG_RESP_POLL:  cfg_q.resp_poll  <= cfg.wdata[7:0];
        sdspi_pkg::CFG_TOKEN_WAIT: cfg_q.token_wait <= cfg.wdata;
        sdspi_pkg::CFG_IDLE_RETRY: cfg_q.idle_retry <= cfg.wdata[7:0];
        sdspi_pkg::CFG_INIT_RETRY: cfg_q.init_retry <= cfg.wdata;
        sdspi_pkg::CFG_BUSY_WAIT:  cfg_q.busy_wait  <= cfg.wdata;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/sdspi_seq.sv
// Sequencer core: input register, next-step logic and result register.
`default_nettype none
module sdspi_seq (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  sdspi_pkg::cfg_t cfg_i,
  sdspi_in_if.sink        in_ch,
  sdspi_out_if.source     out_ch
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_INITCLK, PH_CPRE, PH_FRAME, PH_R1, PH_POST0, PH_FIN, PH_TOKEN,
    PH_RDATA, PH_RCRC, PH_WPRE, PH_WREQ, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [1:0]          op_q, op_d;
  logic [31:0]         addr_q, addr_d;
  logic [sdspi_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0]         poll_q, poll_d;
  logic [15:0]         retry_q, retry_d;
  logic [7:0]          last_q, last_d;
  sdspi_pkg::tag_e     tag_q, tag_d;
  logic [2:0]          pend_q, pend_d;

  logic                iv_q;
  sdspi_pkg::in_t      in_q;
  logic                ov_q;
  sdspi_pkg::out_t     out_q;

  logic                emit;
  logic                sv, sel, rv, dr, dn;
  logic [7:0]          sb, rb;
  logic [2:0]          st;
  logic                stall;
  logic [7:0]          b;

  assign stall       = ov_q && !out_ch.ready;
  assign in_ch.ready = !stall;
  assign out_ch.valid = ov_q;
  assign out_ch.data  = out_q;
  assign b            = in_q.data_byte;

  always_comb begin
    phase_d = phase_q; op_d = op_q; addr_d = addr_q; cnt_d = cnt_q;
    poll_d = poll_q; retry_d = retry_q; last_d = last_q; tag_d = tag_q;
    pend_d = pend_q;
    emit = 1'b0; sv = 1'b0; sb = 8'd0; sel = 1'b0; rv = 1'b0; rb = 8'd0;
    dr = 1'b0; dn = 1'b0; st = 3'd0;
    if (iv_q) begin
      case (in_q.kind)
        sdspi_pkg::KIND_REQ: begin
          if (phase_q == PH_IDLE && in_q.op != 2'd3) begin
            op_d = in_q.op;
            emit = 1'b1; sv = 1'b1; sb = 8'hFF;
            if (in_q.op == sdspi_pkg::OP_INIT) begin
              phase_d = PH_INITCLK; cnt_d = '0;
            end else begin
              addr_d  = (cfg_i.card_type != sdspi_pkg::CardBlock) ?
                        {in_q.sector[22:0], 9'd0} : in_q.sector;
              phase_d = PH_CPRE;
              if (in_q.op == sdspi_pkg::OP_READ) tag_d = sdspi_pkg::T_CMD17;
              else if (cfg_i.card_type != sdspi_pkg::CardMmc) tag_d = sdspi_pkg::T_CMD55W;
              else tag_d = sdspi_pkg::T_CMD24;
            end
          end
        end
        sdspi_pkg::KIND_CARD: begin
          if (phase_q != PH_IDLE && phase_q != PH_WREQ) begin
            emit = 1'b1; sv = 1'b1; sb = 8'hFF; sel = 1'b1;
            case (phase_q)
              PH_INITCLK: begin
                sel = 1'b0;
                if (cnt_q < 10'd10) cnt_d = cnt_q + 10'd1;
                else begin
                  retry_d = '0; tag_d = sdspi_pkg::T_CMD0; phase_d = PH_CPRE;
                end
              end
              PH_CPRE: begin
                phase_d = PH_FRAME; cnt_d = '0;
                sb = sdspi_pkg::frame_byte(tag_q, 3'd0, addr_q);
              end
              PH_FRAME: begin
                if (cnt_q < 10'd5) begin
                  cnt_d = cnt_q + 10'd1;
                  sb = sdspi_pkg::frame_byte(tag_q, cnt_d[2:0], addr_q);
                end else begin
                  phase_d = PH_R1; poll_d = '0;
                end
              end
              PH_R1: begin
                if (b[7] && poll_q < {8'd0, cfg_i.resp_poll}) begin
                  poll_d = poll_q + 16'd1;
                end else begin
                  last_d = b;
                  sel = 1'b0;
                  case (tag_q)
                    sdspi_pkg::T_CMD0: phase_d = PH_POST0;
                    sdspi_pkg::T_CMD8: begin
                      if (b == 8'd1) begin
                        retry_d = '0; tag_d = sdspi_pkg::T_CMD55I; phase_d = PH_CPRE;
                      end else begin
                        pend_d = sdspi_pkg::ST_INIT_ERR; phase_d = PH_FIN;
                      end
                    end
                    sdspi_pkg::T_CMD55I: begin
                      tag_d = sdspi_pkg::T_ACMD41; phase_d = PH_CPRE;
                    end
                    sdspi_pkg::T_ACMD41: begin
                      if (b == 8'd0) begin
                        pend_d = sdspi_pkg::ST_OK; phase_d = PH_FIN;
                      end else if (retry_q < cfg_i.init_retry) begin
                        retry_d = retry_q + 16'd1;
                        tag_d = sdspi_pkg::T_CMD55I; phase_d = PH_CPRE;
                      end else begin
                        pend_d = sdspi_pkg::ST_INIT_ERR; phase_d = PH_FIN;
                      end
                    end
                    sdspi_pkg::T_CMD17: begin
                      if (b != 8'd0) begin
                        pend_d = sdspi_pkg::ST_CMD_ERR; phase_d = PH_FIN;
                      end else begin
                        sel = 1'b1; phase_d = PH_TOKEN; poll_d = '0;
                      end
                    end
                    sdspi_pkg::T_CMD55W: begin
                      tag_d = sdspi_pkg::T_CMD23; phase_d = PH_CPRE;
                    end
                    sdspi_pkg::T_CMD23: begin
                      tag_d = sdspi_pkg::T_CMD24; phase_d = PH_CPRE;
                    end
                    default: begin
                      if (b != 8'd0) begin
                        pend_d = sdspi_pkg::ST_CMD_ERR; phase_d = PH_FIN;
                      end else begin
                        sel = 1'b1; phase_d = PH_WPRE; cnt_d = '0;
                      end
                    end
                  endcase
                end
              end
              PH_POST0: begin
                sel = 1'b0;
                if (last_q == 8'd1) begin
                  tag_d = sdspi_pkg::T_CMD8; phase_d = PH_CPRE;
                end else if (retry_q < {8'd0, cfg_i.idle_retry}) begin
                  retry_d = retry_q + 16'd1; tag_d = sdspi_pkg::T_CMD0; phase_d = PH_CPRE;
                end else begin
                  pend_d = sdspi_pkg::ST_INIT_ERR; phase_d = PH_FIN;
                end
              end
              PH_FIN: begin
                sv = 1'b0; sb = 8'd0; sel = 1'b0; dn = 1'b1; st = pend_q;
                phase_d = PH_IDLE;
              end
              PH_TOKEN: begin
                if (poll_q >= cfg_i.token_wait) begin
                  sel = 1'b0; pend_d = sdspi_pkg::ST_TOKEN_TO; phase_d = PH_FIN;
                end else if (b == 8'hFE) begin
                  phase_d = PH_RDATA; cnt_d = '0;
                end else poll_d = poll_q + 16'd1;
              end
              PH_RDATA: begin
                rv = 1'b1; rb = b;
                if ({1'b0, cnt_q} + 11'd1 < 11'(sdspi_pkg::BlockBytes)) cnt_d = cnt_q + 10'd1;
                else begin
                  phase_d = PH_RCRC; cnt_d = '0;
                end
              end
              PH_RCRC: begin
                if (cnt_q == '0) cnt_d = 10'd1;
                else begin
                  sel = 1'b0; pend_d = sdspi_pkg::ST_OK; phase_d = PH_FIN;
                end
              end
              PH_WPRE: begin
                if (cnt_q < 10'd2) cnt_d = cnt_q + 10'd1;
                else if (cnt_q == 10'd2) begin
                  cnt_d = 10'd3; sb = 8'hFE;
                end else begin
                  sv = 1'b0; sb = 8'd0; sel = 1'b0; dr = 1'b1;
                  phase_d = PH_WREQ; cnt_d = '0;
                end
              end
              PH_WDATA: begin
                if ({1'b0, cnt_q} + 11'd1 < 11'(sdspi_pkg::BlockBytes)) begin
                  cnt_d = cnt_q + 10'd1; phase_d = PH_WREQ;
                  sv = 1'b0; sb = 8'd0; sel = 1'b0; dr = 1'b1;
                end else begin
                  phase_d = PH_WCRC; cnt_d = '0;
                end
              end
              PH_WCRC: begin
                if (cnt_q == '0) cnt_d = 10'd1;
                else phase_d = PH_WRESP;
              end
              PH_WRESP: begin
                last_d = b;
                if (b[4:0] != 5'h05) begin
                  sv = 1'b0; sb = 8'd0; sel = 1'b0; dn = 1'b1;
                  st = sdspi_pkg::ST_WREJECT; phase_d = PH_IDLE;
                end else begin
                  phase_d = PH_BUSY; poll_d = '0;
                end
              end
              PH_BUSY: begin
                if (b != 8'd0) begin
                  sel = 1'b0; pend_d = sdspi_pkg::ST_OK; phase_d = PH_FIN;
                end else if (poll_q >= cfg_i.busy_wait) begin
                  sv = 1'b0; sb = 8'd0; sel = 1'b0; dn = 1'b1;
                  st = sdspi_pkg::ST_BUSY_TO; phase_d = PH_IDLE;
                end else poll_d = poll_q + 16'd1;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        sdspi_pkg::KIND_WDATA: begin
          if (phase_q == PH_WREQ) begin
            phase_d = PH_WDATA;
            emit = 1'b1; sv = 1'b1; sb = b; sel = 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; op_q <= 2'd0; addr_q <= '0; cnt_q <= '0; poll_q <= '0;
      retry_q <= '0; last_q <= 8'hFF; tag_q <= sdspi_pkg::T_CMD0; pend_q <= '0;
      iv_q <= 1'b0; ov_q <= 1'b0;
    end else if (!stall) begin
      phase_q <= phase_d; op_q <= op_d; addr_q <= addr_d; cnt_q <= cnt_d;
      poll_q <= poll_d; retry_q <= retry_d; last_q <= last_d; tag_q <= tag_d;
      pend_q <= pend_d;
      iv_q <= in_ch.valid;
      ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      in_q <= in_ch.data;
      out_q.send_valid   <= sv;
      out_q.send_byte    <= sb;
      out_q.select_low   <= sel;
      out_q.slow_clock   <= sv && (op_d == sdspi_pkg::OP_INIT);
      out_q.read_valid   <= rv;
      out_q.read_byte    <= rb;
      out_q.data_request <= dr;
      out_q.done_res     <= dn;
      out_q.status       <= st;
    end
  end
endmodule
`default_nettype wire

>>> design/sd_spi_mode_host_sequencer_unit.sv
// Top level of the SD SPI-mode host sequencer.
// One item enters per cycle: it is registered in the input register, the next byte
// to exchange is decided by one pass of logic, and the result is registered in the
// output register; a waiting result stalls the input only while the output sink
// holds ready low. Configure only while no beat is in flight.
`default_nettype none
module sd_spi_mode_host_sequencer_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  sdspi_in_if.sink     in_ch,
  sdspi_out_if.source  out_ch,
  sdspi_cfg_if.sink    cfg_ch
);
  sdspi_pkg::cfg_t cfg;

  sdspi_cfg_regs u_cfg (.clk_i, .rst_ni, .cfg(cfg_ch), .cfg_o(cfg));
  sdspi_seq u_seq (.clk_i, .rst_ni, .cfg_i(cfg), .in_ch, .out_ch);

  a_read_has_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.read_valid |-> out_ch.data.send_valid)
    else $error("read byte without exchange");
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.done_res |-> !out_ch.data.send_valid &&
      !out_ch.data.data_request)
    else $error("done with other action");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.done_res |-> out_ch.data.status <= 3'd5)
    else $error("bad status");
endmodule
`default_nettype wire

>>> sim/sdspi_seq_check.sv
// Checker for the SD SPI-mode host sequencer: predicts every result beat and compares it.
`timescale 1ns / 100ps
`default_nettype none
module sdspi_seq_check
  import sdspi_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  in_t        in_data_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  out_t       out_data_i,
  input  wire        cfg_valid_i,
  input  wire        cfg_ready_i,
  input  wire [2:0]  cfg_index_i,
  input  wire [15:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef enum int {
    P_IDLE, P_INITCLK, P_CPRE, P_FRAME, P_R1, P_POST0, P_FIN, P_TOKEN,
    P_RDATA, P_RCRC, P_WPRE, P_WREQ, P_WDATA, P_WCRC, P_WRESP, P_BUSY
  } phase_e;

  logic [1:0]  card_type;
  logic [7:0]  resp_poll;
  logic [15:0] token_wait, init_retry, busy_wait;
  logic [7:0]  idle_retry;

  phase_e      phase;
  logic [1:0]  cur_op;
  logic [31:0] blk_addr;
  int unsigned byte_cnt, poll_cnt, retry_cnt;
  logic [7:0]  last_resp;
  tag_e        tag;
  logic [2:0]  pend_st;

  out_t expected_beats[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_beats.size();

  function automatic logic [7:0] cmd_byte(int unsigned i);
    logic [31:0] arg;
    logic [7:0]  idx;
    logic [7:0]  crc;
    arg = 32'd0;
    crc = 8'h01;
    case (tag)
      T_CMD0:   begin idx = 8'h40; crc = 8'h95; end
      T_CMD8:   begin idx = 8'h48; crc = 8'h87; arg = 32'h1AA; end
      T_ACMD41: begin idx = 8'h69; arg = 32'h4000_0000; end
      T_CMD17:  begin idx = 8'h51; arg = blk_addr; end
      T_CMD23:  begin idx = 8'h57; arg = 32'd1; end
      T_CMD24:  begin idx = 8'h58; arg = blk_addr; end
      default:  idx = 8'h77;
    endcase
    if (i == 0) return idx;
    if (i >= 5) return crc;
    return arg[8*(4-i) +: 8];
  endfunction

  task automatic push_beat(logic sv, logic [7:0] sb, logic sel, logic rv, logic [7:0] rb,
                           logic dr, logic dn, logic [2:0] st);
    out_t o;
    o.send_valid   = sv;
    o.send_byte    = sb;
    o.select_low   = sel;
    o.slow_clock   = sv && (cur_op == OP_INIT);
    o.read_valid   = rv;
    o.read_byte    = rb;
    o.data_request = dr;
    o.done_res     = dn;
    o.status       = st;
    expected_beats.push_back(o);
  endtask

  task automatic xfer(logic [7:0] b, logic sel);
    push_beat(1'b1, b, sel, 1'b0, 8'd0, 1'b0, 1'b0, ST_OK);
  endtask

  task automatic finish_req(status_e st);
    phase = P_IDLE;
    push_beat(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1, st);
  endtask

  task automatic close_req(status_e st);
    pend_st = st;
    phase = P_FIN;
    xfer(8'hFF, 1'b0);
  endtask

  task automatic start_cmd(tag_e t);
    tag = t;
    phase = P_CPRE;
    xfer(8'hFF, 1'b0);
  endtask

  task automatic take_r1(logic [7:0] r1);
    last_resp = r1;
    case (tag)
      T_CMD0: begin
        phase = P_POST0;
        xfer(8'hFF, 1'b0);
      end
      T_CMD8:
        if (r1 == 8'h01) begin
          retry_cnt = 0;
          start_cmd(T_CMD55I);
        end else close_req(ST_INIT_ERR);
      T_CMD55I: start_cmd(T_ACMD41);
      T_ACMD41:
        if (r1 == 8'h00) close_req(ST_OK);
        else if (retry_cnt < init_retry) begin
          retry_cnt++;
          start_cmd(T_CMD55I);
        end else close_req(ST_INIT_ERR);
      T_CMD17:
        if (r1 != 8'h00) close_req(ST_CMD_ERR);
        else begin
          phase = P_TOKEN;
          poll_cnt = 0;
          xfer(8'hFF, 1'b1);
        end
      T_CMD55W: start_cmd(T_CMD23);
      T_CMD23:  start_cmd(T_CMD24);
      default:
        if (r1 != 8'h00) close_req(ST_CMD_ERR);
        else begin
          phase = P_WPRE;
          byte_cnt = 0;
          xfer(8'hFF, 1'b1);
        end
    endcase
  endtask

  task automatic take_card(logic [7:0] b);
    case (phase)
      P_INITCLK:
        if (byte_cnt < 10) begin
          byte_cnt++;
          xfer(8'hFF, 1'b0);
        end else begin
          retry_cnt = 0;
          start_cmd(T_CMD0);
        end
      P_CPRE: begin
        phase = P_FRAME;
        byte_cnt = 0;
        xfer(cmd_byte(0), 1'b1);
      end
      P_FRAME:
        if (byte_cnt < 5) begin
          byte_cnt++;
          xfer(cmd_byte(byte_cnt), 1'b1);
        end else begin
          phase = P_R1;
          poll_cnt = 0;
          xfer(8'hFF, 1'b1);
        end
      P_R1:
        if (b[7] && poll_cnt < resp_poll) begin
          poll_cnt++;
          xfer(8'hFF, 1'b1);
        end else take_r1(b);
      P_POST0:
        if (last_resp == 8'h01) start_cmd(T_CMD8);
        else if (retry_cnt < idle_retry) begin
          retry_cnt++;
          start_cmd(T_CMD0);
        end else close_req(ST_INIT_ERR);
      P_FIN: finish_req(status_e'(pend_st));
      P_TOKEN:
        if (poll_cnt >= token_wait) close_req(ST_TOKEN_TO);
        else if (b == 8'hFE) begin
          phase = P_RDATA;
          byte_cnt = 0;
          xfer(8'hFF, 1'b1);
        end else begin
          poll_cnt++;
          xfer(8'hFF, 1'b1);
        end
      P_RDATA: begin
        if (byte_cnt + 1 < BlockBytes) byte_cnt++;
        else begin
          phase = P_RCRC;
          byte_cnt = 0;
        end
        push_beat(1'b1, 8'hFF, 1'b1, 1'b1, b, 1'b0, 1'b0, ST_OK);
      end
      P_RCRC:
        if (byte_cnt == 0) begin
          byte_cnt = 1;
          xfer(8'hFF, 1'b1);
        end else close_req(ST_OK);
      P_WPRE:
        if (byte_cnt < 2) begin
          byte_cnt++;
          xfer(8'hFF, 1'b1);
        end else if (byte_cnt == 2) begin
          byte_cnt = 3;
          xfer(8'hFE, 1'b1);
        end else begin
          phase = P_WREQ;
          byte_cnt = 0;
          push_beat(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, ST_OK);
        end
      P_WDATA:
        if (byte_cnt + 1 < BlockBytes) begin
          byte_cnt++;
          phase = P_WREQ;
          push_beat(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, ST_OK);
        end else begin
          phase = P_WCRC;
          byte_cnt = 0;
          xfer(8'hFF, 1'b1);
        end
      P_WCRC:
        if (byte_cnt == 0) begin
          byte_cnt = 1;
          xfer(8'hFF, 1'b1);
        end else begin
          phase = P_WRESP;
          xfer(8'hFF, 1'b1);
        end
      P_WRESP: begin
        last_resp = b;
        if (b[4:0] != 5'h05) finish_req(ST_WREJECT);
        else begin
          phase = P_BUSY;
          poll_cnt = 0;
          xfer(8'hFF, 1'b1);
        end
      end
      P_BUSY:
        if (b != 8'h00) close_req(ST_OK);
        else if (poll_cnt >= busy_wait) finish_req(ST_BUSY_TO);
        else begin
          poll_cnt++;
          xfer(8'hFF, 1'b1);
        end
      default: ;
    endcase
  endtask

  task automatic take_item(in_t it);
    case (it.kind)
      KIND_REQ:
        if (phase == P_IDLE && it.op <= OP_WRITE) begin
          cur_op = it.op;
          if (it.op == OP_INIT) begin
            phase = P_INITCLK;
            byte_cnt = 0;
            xfer(8'hFF, 1'b0);
          end else begin
            blk_addr = (card_type != CardBlock) ? (it.sector << 9) : it.sector;
            if (it.op == OP_READ) start_cmd(T_CMD17);
            else if (card_type != CardMmc) start_cmd(T_CMD55W);
            else start_cmd(T_CMD24);
          end
        end
      KIND_CARD:
        if (phase != P_IDLE && phase != P_WREQ) take_card(it.data_byte);
      KIND_WDATA:
        if (phase == P_WREQ) begin
          phase = P_WDATA;
          xfer(it.data_byte, 1'b1);
        end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      card_type = 2'd0;
      resp_poll = 8'd31;
      token_wait = 16'hFFFF;
      idle_retry = 8'd20;
      init_retry = 16'hFFFE;
      busy_wait = 16'hFFFE;
      phase = P_IDLE;
      cur_op = 2'd0;
      blk_addr = 32'd0;
      byte_cnt = 0;
      poll_cnt = 0;
      retry_cnt = 0;
      last_resp = 8'hFF;
      tag = T_CMD0;
      pend_st = 3'd0;
      fails = 0;
      expected_beats.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CARD_TYPE:  card_type  = cfg_wdata_i[1:0];
          CFG_RESP_POLL:  resp_poll  = cfg_wdata_i[7:0];
          CFG_TOKEN_WAIT: token_wait = cfg_wdata_i;
          CFG_IDLE_RETRY: idle_retry = cfg_wdata_i[7:0];
          CFG_INIT_RETRY: init_retry = cfg_wdata_i;
          CFG_BUSY_WAIT:  busy_wait  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %p", out_data_i);
        end else begin
          e = expected_beats.pop_front();
          if (out_data_i !== e) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p actual %p", e, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) take_item(in_data_i);
    end
  end

endmodule
`default_nettype wire

>>> sim/sd_spi_mode_host_sequencer_unit_tb.sv
// Testbench top for the SD SPI-mode host sequencer: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module sd_spi_mode_host_sequencer_unit_tb;
  import sdspi_pkg::*;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct, recv_idle_pct;
  int   items_sent;
  int   fail_count, pending;
  bit   hold_off;
  int   quiet_cycles;

  sdspi_in_if  in_ch ();
  sdspi_out_if out_ch ();
  sdspi_cfg_if cfg_ch ();

  sd_spi_mode_host_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  sdspi_seq_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_index_i  (cfg_ch.index),
    .cfg_wdata_i  (cfg_ch.wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high from one beat to the next unless an idle gap is drawn; drain and flush_idle drop it
  task automatic send_beat(kind_e k, logic [1:0] op, logic [31:0] sec, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data.kind <= k;
    in_ch.data.op   <= op;
    in_ch.data.sector <= sec;
    in_ch.data.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic card(logic [7:0] b);
    send_beat(KIND_CARD, 2'd0, $urandom, b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // one R1 answer: a few busy polls then a byte with bit 7 clear
  task automatic answer_r1(logic [7:0] r1);
    repeat (6) card($urandom);
    card(8'hFF);
    repeat ($urandom_range(2)) card(8'h80 | $urandom);
    card(r1);
  endtask

  task automatic run_init(bit good);
    send_beat(KIND_REQ, OP_INIT, $urandom, $urandom);
    repeat (11) card($urandom);
    card($urandom);
    answer_r1($urandom_range(3) == 0 ? 8'h00 : 8'h01);
    card($urandom);
    card($urandom);
    answer_r1(good ? 8'h01 : 8'h05);
    repeat (2) begin
      card($urandom);
      answer_r1(8'h01);
      card($urandom);
      answer_r1($urandom_range(1) ? 8'h00 : 8'h01);
    end
    repeat (3) card($urandom);
  endtask

  // read that ends on a command error or a token timeout
  task automatic run_read();
    send_beat(KIND_REQ, OP_READ, $urandom, $urandom);
    card($urandom);
    answer_r1($urandom_range(7) == 0 ? 8'h04 : 8'h00);
    repeat (5) card(8'hFD & 8'($urandom));
  endtask

  // no data beats: every command is answered with an error R1; otherwise stop after nbytes
  task automatic run_write(int nbytes);
    send_beat(KIND_REQ, OP_WRITE, $urandom, $urandom);
    repeat (3) begin
      card($urandom);
      answer_r1((nbytes == 0) ? 8'h04 : 8'h00);
    end
    if (nbytes != 0) begin
      repeat (4) card($urandom);
      repeat (nbytes) begin
        if ($urandom_range(9) == 0) card($urandom);
        send_beat(KIND_WDATA, 2'd0, $urandom, $urandom);
        card($urandom);
      end
    end
  endtask

  task automatic noise(int n);
    repeat (n) send_beat(kind_e'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
                         $urandom);
  endtask

  task automatic flush_idle();
    repeat (200) begin
      if (pending == 0 && u_check.phase == 0) break;
      card(8'hFF);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    items_sent = 0;
    hold_off = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 83;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tight limits, extremes
    write_reg(CFG_RESP_POLL, 16'd1);
    write_reg(CFG_TOKEN_WAIT, 16'd1);
    write_reg(CFG_IDLE_RETRY, 16'd1);
    write_reg(CFG_INIT_RETRY, 16'd1);
    write_reg(CFG_BUSY_WAIT, 16'd1);
    write_reg(CFG_CARD_TYPE, 16'd0);
    send_beat(KIND_REQ, OP_READ, 32'hFFFF_FFFF, 8'hFF);
    card(8'h00); repeat (6) card(8'h00);
    card(8'hFF); card(8'hFF); card(8'h00);
    card(8'h00); card(8'h00); card(8'hFE); card(8'h00);
    send_beat(KIND_REQ, 2'd3, 32'd0, 8'h00);
    send_beat(kind_e'(2'd3), 2'd0, 32'd0, 8'h00);
    send_beat(KIND_WDATA, 2'd0, 32'd0, 8'hAA);
    flush_idle();

    write_reg(CFG_RESP_POLL, 16'd255);
    write_reg(CFG_TOKEN_WAIT, 16'hFFFF);
    write_reg(CFG_IDLE_RETRY, 16'd255);
    write_reg(CFG_INIT_RETRY, 16'hFFFF);
    write_reg(CFG_BUSY_WAIT, 16'hFFFF);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 83; recv_idle_pct = 28; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_reg(CFG_CARD_TYPE, 16'($urandom_range(2)));
      write_reg(CFG_RESP_POLL, 16'($urandom_range(1, 3)));
      write_reg(CFG_TOKEN_WAIT, 16'($urandom_range(1, 4)));
      write_reg(CFG_IDLE_RETRY, 16'($urandom_range(1, 3)));
      write_reg(CFG_INIT_RETRY, 16'($urandom_range(1, 4)));
      write_reg(CFG_BUSY_WAIT, 16'($urandom_range(1, 3)));
      run_init($urandom_range(3) != 0);
      flush_idle();
      run_read();
      flush_idle();
      run_write(0);
      flush_idle();
      noise(8);
      flush_idle();
    end

    // hold the receiver off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_beat(KIND_REQ, OP_INIT, 32'd0, 8'd0);
        repeat (40) card($urandom);
      end
    join
    flush_idle();

    // end inside a write block: data beats against card beats
    write_reg(CFG_CARD_TYPE, 16'd0);
    write_reg(CFG_RESP_POLL, 16'd3);
    run_write(30);
    drain();

    repeat (StallLimit / 4) begin
      @(posedge clk_i);
      if (pending == 0) break;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sd_spi_mode_host_sequencer_unit.f
design/sdspi_pkg.sv
design/sdspi_if.sv
design/sdspi_cfg_regs.sv
design/sdspi_seq.sv
design/sd_spi_mode_host_sequencer_unit.sv
sim/sdspi_seq_check.sv
sim/sd_spi_mode_host_sequencer_unit_tb.sv
